@@ rtl/size_class_bucket_allocator_top_assert.svh @@
// Assertion macros used by the allocator controller.
`ifndef SIZE_CLASS_BUCKET_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_BUCKET_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// cond must hold whenever trig holds, in the same cycle
`define SCBA_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle check");
// cond must hold in the cycle after trig
`define SCBA_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle check");
`else
`define SCBA_ASSERT_NOW(lbl, clk, rst_n, trig, cond)
`define SCBA_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)
`endif
`endif

@@ rtl/scba_pkg.sv @@
// Package: types, constants and the bucket size table of the allocator.
`default_nettype none
package scba_pkg;

  localparam int SLOTS_PER_CLASS = 64;
  localparam int NUM_CLASSES     = 7;

  localparam int HEAD_W  = $clog2(SLOTS_PER_CLASS + 1);
  localparam int SLOT_W  = $clog2(SLOTS_PER_CLASS);
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH   = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = HEAD_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] request_size;
    logic [2:0]  free_class;
    logic [5:0]  free_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] size_class;
    logic [5:0] slot_index;
    logic [6:0] class_in_use;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load_item;
    logic commit;
  } cmd_t;

  // Bucket size in bytes per class; zero marks a class without a bucket.
  function automatic logic [15:0] bucket_bytes(input logic [3:0] idx);
    logic [15:0] sz;
    case (idx)
      4'd0:    sz = 16'd32;
      4'd1:    sz = 16'd64;
      4'd2:    sz = 16'd128;
      4'd3:    sz = 16'd252;
      4'd4:    sz = 16'd508;
      4'd5:    sz = 16'd1020;
      4'd6:    sz = 16'd2040;
      default: sz = 16'd0;
    endcase
    return sz;
  endfunction

endpackage
`default_nettype wire

@@ rtl/scba_ctrl.sv @@
// Controller: item sequencing and output valid.
`default_nettype none
`include "size_class_bucket_allocator_top_assert.svh"
module scba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output scba_pkg::cmd_t     cmd
);
  import scba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SCBA_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_valid && !in_stall, state_r == ST_EXEC)
  `SCBA_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_r && state_r == ST_IDLE)
  `SCBA_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.commit && out_valid_r, !out_stall)

endmodule
`default_nettype wire

@@ rtl/scba_dp.sv @@
// Datapath: class select, free list heads, link memory and result register.
`default_nettype none
module scba_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scba_pkg::cmd_t       cmd,
  input  wire scba_pkg::in_item_t   in_data,
  output scba_pkg::out_item_t       out_data
);
  import scba_pkg::*;

  // per-class control state
  logic [HEAD_W-1:0] free_head_r [NUM_CLASSES];
  logic [HEAD_W-1:0] fill_r      [NUM_CLASSES];
  logic [HEAD_W-1:0] count_r     [NUM_CLASSES];

  // entry: {taken, link}
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_r;

  // latched item
  logic              op_r;
  logic              cls_ok_r;
  logic [CLS_W-1:0]  cls_idx_r;
  logic [2:0]        fc_r;
  logic [5:0]        fs_r;
  logic              fs_big_r;
  logic [ADDR_W-1:0] addr_r;

  out_item_t out_r, out_nxt;

  // load-side signals
  logic              found;
  logic [CLS_W-1:0]  sel;
  logic              fc_ok;
  logic              fs_big;
  logic [CLS_W-1:0]  ld_cls;
  logic [SLOT_W-1:0] ld_slot;
  logic              ld_ok;
  logic [ADDR_W-1:0] ld_addr;

  // commit-side signals
  logic [HEAD_W-1:0]  head_c, fill_c, cnt_c;
  logic [HEAD_W-1:0]  rd_link;
  logic               taken;
  logic               wr_en;
  logic [ENTRY_W-1:0] wdata;
  logic               upd;
  logic [HEAD_W-1:0]  head_nxt, fill_nxt, cnt_nxt;

  // smallest class whose bucket fits the request
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (bucket_bytes(4'(c)) != 16'd0 && in_data.request_size <= bucket_bytes(4'(c))) begin
        found = 1'b1;
        sel   = CLS_W'(c);
      end
    end
  end

  always_comb begin
    fc_ok  = (32'(in_data.free_class) < NUM_CLASSES);
    fs_big = (32'(in_data.free_slot) >= SLOTS_PER_CLASS);
    if (in_data.op == OP_ALLOC) begin
      ld_cls  = sel;
      ld_slot = free_head_r[sel][SLOT_W-1:0];
      ld_ok   = found;
    end else begin
      ld_cls  = fc_ok ? CLS_W'(in_data.free_class) : '0;
      ld_slot = SLOT_W'(in_data.free_slot);
      ld_ok   = fc_ok && !fs_big;
    end
    ld_addr = ld_ok ? ADDR_W'(ADDR_W'(ld_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(ld_slot))
                    : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r      <= in_data.op;
      cls_ok_r  <= (in_data.op == OP_ALLOC) ? found : fc_ok;
      cls_idx_r <= ld_cls;
      fc_r      <= in_data.free_class;
      fs_r      <= in_data.free_slot;
      fs_big_r  <= fs_big;
      addr_r    <= ld_addr;
      rd_r      <= mem[ld_addr];
    end
    if (wr_en) begin
      mem[addr_r] <= wdata;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    head_c   = free_head_r[cls_idx_r];
    fill_c   = fill_r[cls_idx_r];
    cnt_c    = count_r[cls_idx_r];
    rd_link  = rd_r[HEAD_W-1:0];
    // slots at or past the fill mark were never handed out
    taken    = rd_r[HEAD_W] && (HEAD_W'(fs_r) < fill_c);
    wr_en    = 1'b0;
    wdata    = '0;
    upd      = 1'b0;
    head_nxt = head_c;
    fill_nxt = fill_c;
    cnt_nxt  = cnt_c;
    out_nxt  = '0;
    if (op_r == OP_ALLOC) begin
      if (!cls_ok_r) begin
        out_nxt.status = STAT_TOO_LARGE;
      end else if (32'(head_c) >= SLOTS_PER_CLASS) begin
        out_nxt.status       = STAT_EXHAUSTED;
        out_nxt.size_class   = 3'(cls_idx_r);
        out_nxt.class_in_use = 7'(cnt_c);
      end else begin
        upd   = 1'b1;
        wr_en = 1'b1;
        wdata = {1'b1, rd_link};
        if (head_c == fill_c) begin
          // untouched tail: link is the next slot
          head_nxt = head_c + HEAD_W'(1);
          fill_nxt = fill_c + HEAD_W'(1);
        end else begin
          head_nxt = rd_link;
        end
        cnt_nxt              = cnt_c + HEAD_W'(1);
        out_nxt.status       = STAT_OK;
        out_nxt.size_class   = 3'(cls_idx_r);
        out_nxt.slot_index   = 6'(head_c);
        out_nxt.class_in_use = 7'(cnt_nxt);
      end
    end else begin
      out_nxt.size_class = fc_r;
      out_nxt.slot_index = fs_r;
      if (!cls_ok_r) begin
        out_nxt.status = STAT_BAD_FREE;
      end else if (fs_big_r || !taken) begin
        out_nxt.status       = STAT_BAD_FREE;
        out_nxt.class_in_use = 7'(cnt_c);
      end else begin
        upd      = 1'b1;
        wr_en    = 1'b1;
        wdata    = {1'b0, head_c};
        head_nxt = HEAD_W'(fs_r);
        if (cnt_c != '0) begin
          cnt_nxt = cnt_c - HEAD_W'(1);
        end
        out_nxt.status       = STAT_OK;
        out_nxt.class_in_use = 7'(cnt_nxt);
      end
    end
    if (!cmd.commit) begin
      wr_en = 1'b0;
      upd   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_head_r[c] <= '0;
        fill_r[c]      <= '0;
        count_r[c]     <= '0;
      end
    end else if (upd) begin
      free_head_r[cls_idx_r] <= head_nxt;
      fill_r[cls_idx_r]      <= fill_nxt;
      count_r[cls_idx_r]     <= cnt_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

@@ rtl/size_class_bucket_allocator_top.sv @@
// Each item is accepted, then committed into the output register, where out_valid shows it.
// A new item is accepted only once the last has committed; a stalled result holds the commit.
// The separate commit step follows the registered read of the link memory in the accept cycle.
// A finished item waits in the output register while the next item is accepted.
// Reset: synchronous, active low; heads, fill marks and counts clear at once, no sweep.
// The link memory needs no clearing: a per-class fill mark stands in for its reset contents.
`default_nettype none
module size_class_bucket_allocator_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire scba_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output scba_pkg::out_item_t       out_data
);
  import scba_pkg::*;

  // commands from the sequencer to the datapath
  cmd_t cmd;

  // sequence each item: accept, then commit once the output register is free
  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // class select, free lists, link memory and result register
  scba_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

@@ sim/tb_size_class_bucket_allocator_top.sv @@
// Testbench for the size-class slot allocator: random and directed requests, self-checking.
`default_nettype none
module tb_size_class_bucket_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scba_pkg::*;

  // Bucket size in bytes of each class, smallest first.
  localparam int unsigned BUCKET_LIMIT [NUM_CLASSES] = '{32, 64, 128, 252, 508, 1020, 2040};
  localparam int unsigned RANDOM_ITEMS = 950;

  // One queued request, the idle cycles to leave after it, and whether it
  // must wait until every outstanding result is back.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          settle;
  } request_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [5:0] slot;
  } slot_ref_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow copy of the allocator state.
  logic [HEAD_W-1:0] head_q [NUM_CLASSES];
  logic [HEAD_W-1:0] link_q [NUM_CLASSES][SLOTS_PER_CLASS];
  bit                taken_q [NUM_CLASSES][SLOTS_PER_CLASS];
  logic [6:0]        used_q [NUM_CLASSES];

  request_t    request_q [$];      // items waiting for the driver
  out_item_t   owed_results [$];   // predicted results, oldest first
  slot_ref_t   held_slots [$];     // slots handed out and not yet picked for release
  int          errors = 0;
  logic        in_fired = 1'b0;    // the item on the input took at the last rising edge
  int unsigned gap_left = 0;
  int unsigned calm_items = 0;

  always #5 clk = ~clk;

  size_class_bucket_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Apply one request to the shadow state and return the result it must give.
  function automatic out_item_t allocate_or_release(in_item_t req);
    out_item_t   res;
    int          cls;
    int          k;
    int unsigned slot;
    res = '0;
    if (req.op == OP_ALLOC) begin
      // smallest class whose bucket holds the request
      cls = -1;
      for (k = NUM_CLASSES - 1; k >= 0; k--) begin
        if (32'(req.request_size) <= BUCKET_LIMIT[k]) cls = k;
      end
      if (cls < 0) begin
        res.status = STAT_TOO_LARGE;
        return res;
      end
      res.size_class = 3'(cls);
      if (32'(head_q[cls]) >= SLOTS_PER_CLASS) begin
        // no fallback to a larger class
        res.status = STAT_EXHAUSTED;
        res.class_in_use = used_q[cls];
        return res;
      end
      slot = 32'(head_q[cls]);
      head_q[cls] = link_q[cls][slot];
      taken_q[cls][slot] = 1'b1;
      used_q[cls] = 7'(used_q[cls] + 7'd1);
      res.status = STAT_OK;
      res.slot_index = 6'(slot);
      res.class_in_use = used_q[cls];
      held_slots.push_back({3'(cls), 6'(slot)});
      return res;
    end
    res.status = STAT_BAD_FREE;
    res.size_class = req.free_class;
    res.slot_index = req.free_slot;
    if (32'(req.free_class) >= NUM_CLASSES) return res;
    cls = int'(req.free_class);
    slot = 32'(req.free_slot);
    res.class_in_use = used_q[cls];
    if (!taken_q[cls][slot]) return res;
    // push the slot back on the head of its list
    link_q[cls][slot] = head_q[cls];
    head_q[cls] = HEAD_W'(slot);
    taken_q[cls][slot] = 1'b0;
    if (used_q[cls] != 7'd0) used_q[cls] = 7'(used_q[cls] - 7'd1);
    res.status = STAT_OK;
    res.class_in_use = used_q[cls];
    return res;
  endfunction

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Check results and predict accepted items at the rising edge.
  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual status %0d class %0d slot %0d",
                   $time, out_data.status, out_data.size_class, out_data.slot_index);
        end else begin
          want = owed_results.pop_front();
          report_field("status", 16'(want.status), 16'(out_data.status));
          report_field("size_class", 16'(want.size_class), 16'(out_data.size_class));
          report_field("slot_index", 16'(want.slot_index), 16'(out_data.slot_index));
          report_field("class_in_use", 16'(want.class_in_use), 16'(out_data.class_in_use));
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(allocate_or_release(in_data));
    end
  end

  // Drive requests at the falling edge; hold a stalled item unchanged.
  always @(negedge clk) begin : feed_requests
    logic drive;
    drive = in_valid && !in_fired;
    if (!rst_n) begin
      drive = 1'b0;
    end else if (!drive) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (request_q.size() != 0) begin
        // a settling item waits until every result is back
        if (!request_q[0].settle || owed_results.size() == 0) begin
          in_data <= request_q[0].item;
          gap_left = request_q[0].gap;
          void'(request_q.pop_front());
          drive = 1'b1;
        end
      end
    end
    in_valid <= drive;
  end

  // Stall the result side: mostly short bursts, a few long ones, some calm stretches.
  always @(negedge clk) begin : hold_results
    int unsigned pick;
    int unsigned stall_left;
    int unsigned calm_left;
    if (calm_left != 0) begin
      calm_left = calm_left - 1;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        calm_left = $urandom_range(30, 100);
        out_stall <= 1'b0;
      end else if (pick < 60) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // Idle cycles after an item: mostly none or a few, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (calm_items != 0) begin
      calm_items--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) calm_items = $urandom_range(20, 60);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t alloc_req(logic [15:0] size);
    in_item_t it;
    it.op = OP_ALLOC;
    it.request_size = size;
    it.free_class = 3'($urandom_range(0, 7));
    it.free_slot = 6'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic in_item_t free_req(logic [2:0] cls, logic [5:0] slot);
    in_item_t it;
    it.op = OP_FREE;
    it.request_size = 16'($urandom_range(0, 65535));
    it.free_class = cls;
    it.free_slot = slot;
    return it;
  endfunction

  // A request size that lands in the given class, edges favored.
  function automatic logic [15:0] size_for(int cls);
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    lo = (cls == 0) ? 0 : BUCKET_LIMIT[cls - 1] + 1;
    hi = BUCKET_LIMIT[cls];
    pick = $urandom_range(0, 3);
    if (pick == 0) return 16'(lo);
    if (pick == 1) return 16'(hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  // Queue one item, keeping the queue short so generation follows the predictor.
  task automatic queue_item(in_item_t it, bit settle);
    request_t req;
    while (request_q.size() >= 4) @(posedge clk);
    req.item = it;
    req.gap = pick_gap();
    req.settle = settle;
    request_q.push_back(req);
  endtask

  task automatic release_held();
    slot_ref_t   ref_pick;
    int unsigned idx;
    if (held_slots.size() == 0) begin
      queue_item(free_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63))), 1'b0);
    end else begin
      idx = $urandom_range(0, held_slots.size() - 1);
      ref_pick = held_slots[idx];
      held_slots.delete(idx);
      queue_item(free_req(ref_pick.cls, ref_pick.slot), 1'b0);
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned mode;
    int unsigned run;
    int unsigned pick;
    int          cls;
    int          c;
    int          k;
    slot_ref_t   last_freed;
    for (c = 0; c < NUM_CLASSES; c++) begin
      head_q[c] = '0;
      used_q[c] = '0;
      for (k = 0; k < SLOTS_PER_CLASS; k++) begin
        link_q[c][k] = HEAD_W'(k + 1);
        taken_q[c][k] = 1'b0;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bucket edges, oversize requests, every kind of bad free, reuse.
    queue_item(alloc_req(16'd0), 1'b0);
    queue_item(alloc_req(16'd32), 1'b0);
    queue_item(alloc_req(16'd33), 1'b0);
    queue_item(alloc_req(16'd64), 1'b0);
    queue_item(alloc_req(16'd65), 1'b0);
    queue_item(alloc_req(16'd128), 1'b0);
    queue_item(alloc_req(16'd129), 1'b0);
    queue_item(alloc_req(16'd252), 1'b0);
    queue_item(alloc_req(16'd253), 1'b0);
    queue_item(alloc_req(16'd508), 1'b0);
    queue_item(alloc_req(16'd509), 1'b0);
    queue_item(alloc_req(16'd1020), 1'b0);
    queue_item(alloc_req(16'd1021), 1'b0);
    queue_item(alloc_req(16'd2040), 1'b0);
    queue_item(alloc_req(16'd2041), 1'b0);
    queue_item(alloc_req(16'hFFFF), 1'b0);
    queue_item(free_req(3'd7, 6'd63), 1'b0);
    queue_item(free_req(3'd0, 6'd63), 1'b0);
    queue_item(free_req(3'd0, 6'd1), 1'b0);
    queue_item(free_req(3'd0, 6'd1), 1'b0);
    // wait for the pipeline to empty, then reuse the slot just released
    queue_item(alloc_req(16'd1), 1'b1);
    queue_item(free_req(3'd6, 6'd0), 1'b0);

    // Random phases: mixed traffic, filling one class past exhaustion, draining.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = (phase == 0) ? 5 : $urandom_range(0, 9);
      phase++;
      if (mode < 5) begin
        run = $urandom_range(30, 60);
        repeat (run) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            queue_item(alloc_req(size_for($urandom_range(0, NUM_CLASSES - 1))), 1'b0);
          end else if (pick < 52) begin
            queue_item(alloc_req(16'($urandom_range(0, 65535))), 1'b0);
          end else if (pick < 88) begin
            release_held();
          end else begin
            queue_item(free_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63))), 1'b0);
          end
        end
        sent += run;
      end else if (mode < 8) begin
        // every allocation goes to one class, enough to run it dry
        cls = (phase == 1) ? 0 : $urandom_range(0, NUM_CLASSES - 1);
        run = SLOTS_PER_CLASS + $urandom_range(1, 8);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_item(free_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63))), 1'b0);
            sent++;
          end
          queue_item(alloc_req(size_for(cls)), 1'b0);
        end
        sent += run;
      end else begin
        // release everything held; start only once the block has caught up
        queue_item(free_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63))), 1'b1);
        sent++;
        last_freed = '0;
        while (held_slots.size() != 0 && sent < RANDOM_ITEMS) begin
          pick = $urandom_range(0, 99);
          if (pick < 5) begin
            queue_item(free_req(last_freed.cls, last_freed.slot), 1'b0);
          end else begin
            k = $urandom_range(0, held_slots.size() - 1);
            last_freed = held_slots[k];
            held_slots.delete(k);
            queue_item(free_req(last_freed.cls, last_freed.slot), 1'b0);
          end
          sent++;
        end
      end
    end

    // Let the last item go in, then every result come back.
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ctrl.sv
rtl/scba_dp.sv
rtl/size_class_bucket_allocator_top.sv
sim/tb_size_class_bucket_allocator_top.sv
